// ===== rtl/sat_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sat_pkg;

    // Fixed field widths
    localparam int IDX_W   = 6;
    localparam int CNT_W   = 7;
    localparam int SIZE_W  = 32;
    localparam int OWNER_W = 8;
    localparam int COLOR_W = 3;

    // Color given to reserved slots at reset
    localparam logic [COLOR_W-1:0] RESERVED_COLOR = COLOR_W'(1);

    typedef enum logic [1:0] {
        OP_ALLOC      = 2'd0,
        OP_FREE       = 2'd1,
        OP_FREE_OWNER = 2'd2,
        OP_QUERY      = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_BAD  = 2'd2
    } status_t;

    // Request token walking down the slot chain
    typedef struct packed {
        op_t                op;
        logic [OWNER_W-1:0] owner;
        logic [COLOR_W-1:0] color;
        logic [SIZE_W-1:0]  size;
        logic [IDX_W-1:0]   idx;
        logic               pending;    // allocate still looking for a free slot
        logic               hit;        // free/query found a used slot at idx
        logic [IDX_W-1:0]   granted;
        logic [SIZE_W-1:0]  qsize;
        logic [SIZE_W-1:0]  freed_sum;
        logic [CNT_W-1:0]   count;
    } sat_tok_t;

    // One result beat
    typedef struct packed {
        logic [SIZE_W-1:0] bytes_freed;
        logic [SIZE_W-1:0] bytes_allocated;
        logic [CNT_W-1:0]  active_slots;
        logic [SIZE_W-1:0] slot_size;
        logic [IDX_W-1:0]  granted_slot;
        status_t           status;
    } sat_res_t;

endpackage

`default_nettype wire

// ===== rtl/sat_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sat_cell #(
    parameter int CELL_IDX       = 0,
    parameter int RESERVED_SLOTS = 5
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    input  wire sat_pkg::sat_tok_t in_tok,
    output logic                   out_valid,
    output sat_pkg::sat_tok_t      out_tok
);
    import sat_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX   = IDX_W'(CELL_IDX);
    localparam logic             RSV      = (CELL_IDX < RESERVED_SLOTS);

    logic               used_reg,  used_next;
    logic [OWNER_W-1:0] owner_reg, owner_next;
    logic [COLOR_W-1:0] color_reg, color_next;
    logic [SIZE_W-1:0]  bytes_reg, bytes_next;
    logic               out_valid_reg;
    sat_tok_t           out_tok_reg, tok_next;

    // Per-slot operation on the passing token
    always_comb begin
        used_next  = used_reg;
        owner_next = owner_reg;
        color_next = color_reg;
        bytes_next = bytes_reg;
        tok_next   = in_tok;
        if (in_valid) begin
            unique case (in_tok.op)
                OP_ALLOC: begin
                    if (in_tok.pending && !used_reg) begin
                        used_next        = 1'b1;
                        owner_next       = in_tok.owner;
                        color_next       = in_tok.color;
                        bytes_next       = in_tok.size;
                        tok_next.pending = 1'b0;
                        tok_next.granted = MY_IDX;
                    end
                end
                OP_FREE: begin
                    if (in_tok.idx == MY_IDX && used_reg) begin
                        tok_next.freed_sum = in_tok.freed_sum + bytes_reg;
                        tok_next.hit       = 1'b1;
                        used_next          = 1'b0;
                        owner_next         = '0;
                        color_next         = '0;
                        bytes_next         = '0;
                    end
                end
                OP_FREE_OWNER: begin
                    if (used_reg && owner_reg == in_tok.owner) begin
                        tok_next.freed_sum = in_tok.freed_sum + bytes_reg;
                        used_next          = 1'b0;
                        owner_next         = '0;
                        color_next         = '0;
                        bytes_next         = '0;
                    end
                end
                OP_QUERY: begin
                    if (in_tok.idx == MY_IDX && used_reg) begin
                        tok_next.qsize = bytes_reg;
                        tok_next.hit   = 1'b1;
                    end
                end
            endcase
            // running count of used slots after this operation
            tok_next.count = in_tok.count + CNT_W'(used_next);
        end
    end

    // Slot state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg  <= RSV;
            owner_reg <= '0;
            color_reg <= RSV ? RESERVED_COLOR : '0;
            bytes_reg <= '0;
        end else begin
            used_reg  <= used_next;
            owner_reg <= owner_next;
            color_reg <= color_next;
            bytes_reg <= bytes_next;
        end
    end

    // Hand token to the next cell
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        out_tok_reg <= tok_next;
    end

    assign out_valid = out_valid_reg;
    assign out_tok   = out_tok_reg;

endmodule

`default_nettype wire

// ===== rtl/slot_allocation_table.sv =====
`timescale 1ns / 1ps
`default_nettype none
// An accepted s_ beat passes every cell register and then the output register
// before m_tvalid. The token walks the cells one per cycle, and the next beat
// is taken the cycle after it leaves unless its result went to the skid stage.
// One finished result may wait on m_ while the next request runs.
// Reset (aresetn low, synchronous) restores the table at once: the first
// RESERVED_SLOTS slots used with owner 0 and color 1, totals zero.

module slot_allocation_table #(
    parameter int SLOT_COUNT     = 60,
    parameter int RESERVED_SLOTS = 5
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // operation[1:0], owner_tag[9:2], color_tag[12:10],
    // request_size[44:13], slot_index[50:45]
    input  wire logic [55:0]  s_tdata,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // status[1:0], granted_slot[7:2], slot_size[39:8], active_slots[46:40],
    // bytes_allocated[78:47], bytes_freed[110:79]
    output logic [111:0]      m_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready
);
    import sat_pkg::*;

    logic     tok_valid [0:SLOT_COUNT];
    sat_tok_t tok       [0:SLOT_COUNT];

    logic              busy_reg;
    logic              out_valid_reg, skid_valid_reg;
    sat_res_t          out_res_reg, skid_res_reg, res;
    logic [SIZE_W-1:0] alloc_total_reg, freed_total_reg;
    logic [SIZE_W-1:0] alloc_total_next, freed_total_next;
    logic              s_fire, exit_valid, out_load, alloc_ok;
    sat_tok_t          exit_tok, head_tok;

    assign s_tready = !busy_reg && !skid_valid_reg;
    assign s_fire   = s_tvalid && s_tready;

    // Build the request token
    always_comb begin
        head_tok.op        = op_t'(s_tdata[1:0]);
        head_tok.owner     = s_tdata[9:2];
        head_tok.color     = s_tdata[12:10];
        head_tok.size      = s_tdata[44:13];
        head_tok.idx       = s_tdata[50:45];
        head_tok.pending   = (op_t'(s_tdata[1:0]) == OP_ALLOC);
        head_tok.hit       = 1'b0;
        head_tok.granted   = '0;
        head_tok.qsize     = '0;
        head_tok.freed_sum = '0;
        head_tok.count     = '0;
    end

    assign tok_valid[0] = s_fire;
    assign tok[0]       = head_tok;

    // Chain of slot cells
    for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
        sat_cell #(
            .CELL_IDX       (g),
            .RESERVED_SLOTS (RESERVED_SLOTS)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (tok_valid[g]),
            .in_tok    (tok[g]),
            .out_valid (tok_valid[g+1]),
            .out_tok   (tok[g+1])
        );
    end

    assign exit_valid = tok_valid[SLOT_COUNT];
    assign exit_tok   = tok[SLOT_COUNT];

    // Final status and running totals
    always_comb begin
        alloc_ok   = 1'b0;
        res.status = ST_OK;
        case (exit_tok.op) inside
            OP_ALLOC: begin
                alloc_ok   = !exit_tok.pending;
                res.status = exit_tok.pending ? ST_FULL : ST_OK;
            end
            OP_FREE, OP_QUERY: begin
                res.status = exit_tok.hit ? ST_OK : ST_BAD;
            end
            default: begin
                res.status = ST_OK;
            end
        endcase
        alloc_total_next    = alloc_total_reg + (alloc_ok ? exit_tok.size : '0);
        freed_total_next    = freed_total_reg + exit_tok.freed_sum;
        res.granted_slot    = exit_tok.granted;
        res.slot_size       = exit_tok.qsize;
        res.active_slots    = exit_tok.count;
        res.bytes_allocated = alloc_total_next;
        res.bytes_freed     = freed_total_next;
    end

    assign out_load = !out_valid_reg || m_tready;

    // Control: busy flag, running totals, output register and skid stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
            skid_valid_reg  <= 1'b0;
            alloc_total_reg <= '0;
            freed_total_reg <= '0;
        end else begin
            if (s_fire) begin
                busy_reg <= 1'b1;
            end else if (exit_valid) begin
                busy_reg <= 1'b0;
            end
            if (exit_valid) begin
                alloc_total_reg <= alloc_total_next;
                freed_total_reg <= freed_total_next;
            end
            if (out_load) begin
                out_valid_reg  <= skid_valid_reg || exit_valid;
                skid_valid_reg <= 1'b0;
            end else if (exit_valid) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_res_reg <= skid_valid_reg ? skid_res_reg : res;
        end
        if (exit_valid && !out_load) begin
            skid_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_res_reg};

`ifndef SYNTHESIS
    // A token leaves the chain only when the skid stage is free
    assert property (@(posedge aclk) disable iff (!aresetn)
        exit_valid |-> !skid_valid_reg)
        else $error("token exit with skid stage occupied");

    // Accepted request keeps the block busy
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> busy_reg && !s_tready)
        else $error("request accepted while not busy afterwards");

    // Used-slot count stays within the table
    assert property (@(posedge aclk) disable iff (!aresetn)
        exit_valid |-> exit_tok.count <= CNT_W'(SLOT_COUNT))
        else $error("active slot count out of range");

    // A granted slot lies inside the table
    assert property (@(posedge aclk) disable iff (!aresetn)
        (exit_valid && exit_tok.op == OP_ALLOC && !exit_tok.pending)
            |-> int'(exit_tok.granted) < SLOT_COUNT)
        else $error("granted slot out of range");
`endif

endmodule

`default_nettype wire

// ===== verif/sat_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels of the slot table, keeps its own copy of the table,
// predicts each result beat and compares it with what the block returns.
module sat_checker #(
    parameter int SLOT_COUNT     = 60,
    parameter int RESERVED_SLOTS = 5
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic [55:0]  s_tdata,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic [111:0] m_tdata,
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    output int                mismatches,
    output int                pending,
    output int                results_seen,
    output int                full_seen,
    output int                bad_seen,
    output int                peak_used
);
    import sat_pkg::*;

    // Request beat layout, lowest field last
    typedef struct packed {
        logic [4:0]         pad;
        logic [IDX_W-1:0]   idx;
        logic [SIZE_W-1:0]  size;
        logic [COLOR_W-1:0] color;
        logic [OWNER_W-1:0] owner;
        op_t                op;
    } sat_req_t;

    // Shadow copy of the slot table and the running totals
    logic               tbl_used  [SLOT_COUNT];
    logic [OWNER_W-1:0] tbl_owner [SLOT_COUNT];
    logic [COLOR_W-1:0] tbl_color [SLOT_COUNT];
    logic [SIZE_W-1:0]  tbl_bytes [SLOT_COUNT];
    logic [SIZE_W-1:0]  alloc_sum;
    logic [SIZE_W-1:0]  freed_sum;
    logic [CNT_W-1:0]   live_slots;

    // Results predicted but not yet returned, oldest first
    sat_res_t           expected_results [$];

    function automatic void clear_table();
        for (int i = 0; i < SLOT_COUNT; i++) begin
            tbl_used[i]  = (i < RESERVED_SLOTS);
            tbl_owner[i] = '0;
            tbl_color[i] = (i < RESERVED_SLOTS) ? RESERVED_COLOR : '0;
            tbl_bytes[i] = '0;
        end
        alloc_sum  = '0;
        freed_sum  = '0;
        live_slots = CNT_W'(RESERVED_SLOTS);
    endfunction

    // Release one slot: its size goes to the freed total, the slot goes blank
    function automatic void drop_slot(input int i);
        freed_sum    = freed_sum + tbl_bytes[i];
        tbl_used[i]  = 1'b0;
        tbl_owner[i] = '0;
        tbl_color[i] = '0;
        tbl_bytes[i] = '0;
        live_slots   = live_slots - 1'b1;
    endfunction

    // Apply one request to the shadow table and build the result it causes
    function automatic sat_res_t apply_request(input sat_req_t req);
        sat_res_t res;
        bit       hit;
        res        = '0;
        res.status = ST_OK;
        hit        = (int'(req.idx) < SLOT_COUNT) && tbl_used[req.idx];
        case (req.op)
            OP_ALLOC: begin
                // first fit: lowest free slot wins
                res.status = ST_FULL;
                for (int i = 0; i < SLOT_COUNT; i++) begin
                    if (res.status == ST_FULL && !tbl_used[i]) begin
                        tbl_used[i]      = 1'b1;
                        tbl_owner[i]     = req.owner;
                        tbl_color[i]     = req.color;
                        tbl_bytes[i]     = req.size;
                        alloc_sum        = alloc_sum + req.size;
                        live_slots       = live_slots + 1'b1;
                        res.granted_slot = IDX_W'(i);
                        res.status       = ST_OK;
                    end
                end
            end
            OP_FREE: begin
                if (hit) drop_slot(int'(req.idx));
                else res.status = ST_BAD;
            end
            OP_FREE_OWNER: begin
                // never fails, even with no match
                for (int i = 0; i < SLOT_COUNT; i++) begin
                    if (tbl_used[i] && tbl_owner[i] == req.owner) drop_slot(i);
                end
            end
            OP_QUERY: begin
                if (hit) res.slot_size = tbl_bytes[req.idx];
                else res.status = ST_BAD;
            end
        endcase
        res.active_slots    = live_slots;
        res.bytes_allocated = alloc_sum;
        res.bytes_freed     = freed_sum;
        return res;
    endfunction

    function automatic void flag_error(input string why, input sat_res_t want,
                                       input sat_res_t got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t %s: exp st=%0d slot=%0d size=%h used=%0d alloc=%h freed=%h",
                     $realtime, why, want.status, want.granted_slot, want.slot_size,
                     want.active_slots, want.bytes_allocated, want.bytes_freed);
            $display("    got st=%0d slot=%0d size=%h used=%0d alloc=%h freed=%h",
                     got.status, got.granted_slot, got.slot_size,
                     got.active_slots, got.bytes_allocated, got.bytes_freed);
        end
    endfunction

    // Predict on every accepted request beat, compare on every result beat
    always @(posedge aclk) begin : watch
        sat_res_t exp_res;
        sat_res_t got_res;
        if (!aresetn) begin
            clear_table();
            expected_results.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                exp_res = apply_request(sat_req_t'(s_tdata));
                expected_results.push_back(exp_res);
                if (exp_res.status == ST_FULL) full_seen++;
                if (exp_res.status == ST_BAD) bad_seen++;
                if (int'(live_slots) > peak_used) peak_used = int'(live_slots);
            end
            if (m_tvalid && m_tready) begin
                got_res = sat_res_t'(m_tdata[110:0]);
                results_seen++;
                if (expected_results.size() == 0) begin
                    flag_error("unexpected result", '0, got_res);
                end else begin
                    exp_res = expected_results.pop_front();
                    if (got_res.status !== exp_res.status
                        || got_res.granted_slot !== exp_res.granted_slot
                        || got_res.slot_size !== exp_res.slot_size
                        || got_res.active_slots !== exp_res.active_slots
                        || got_res.bytes_allocated !== exp_res.bytes_allocated
                        || got_res.bytes_freed !== exp_res.bytes_freed) begin
                        flag_error("result mismatch", exp_res, got_res);
                    end
                end
            end
        end
        pending <= expected_results.size();
    end

endmodule

// ===== verif/tb_slot_allocation_table.sv =====
`timescale 1ns / 1ps

module tb_slot_allocation_table;
    import sat_pkg::*;

    localparam int SLOT_COUNT     = 60;
    localparam int RESERVED_SLOTS = 5;
    localparam int RANDOM_ITEMS   = 1500;
    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int HOLD_AFTER     = 400;    // request beats before the long hold-off
    localparam int HOLD_CYCLES    = 600;

    typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIX} traffic_t;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic [55:0]  s_tdata  = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [111:0] m_tdata;
    logic         m_tvalid;
    logic         m_tready = 1'b0;

    int           mismatches;
    int           pending;
    int           results_seen;
    int           full_seen;
    int           bad_seen;
    int           peak_used;

    int           burst_left;
    int           rx_accepts;
    int           stall_left;
    bit           held;
    logic [9:0]   rx_phase = '0;

    initial begin : clock
        forever #2 aclk = ~aclk;
    end

    slot_allocation_table #(
        .SLOT_COUNT     (SLOT_COUNT),
        .RESERVED_SLOTS (RESERVED_SLOTS)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    sat_checker #(
        .SLOT_COUNT     (SLOT_COUNT),
        .RESERVED_SLOTS (RESERVED_SLOTS)
    ) checker_i (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tdata      (s_tdata),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .m_tdata      (m_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .mismatches   (mismatches),
        .pending      (pending),
        .results_seen (results_seen),
        .full_seen    (full_seen),
        .bad_seen     (bad_seen),
        .peak_used    (peak_used)
    );

    function automatic logic [55:0] pack_req(input op_t op, input logic [7:0] owner,
                                             input logic [2:0] color,
                                             input logic [31:0] size,
                                             input logic [5:0] idx);
        return {5'd0, idx, size, color, owner, op};
    endfunction

    // Random request; fill and drain modes skew the op mix, mix mode picks evenly
    function automatic logic [55:0] random_req(input traffic_t mode);
        int          roll;
        op_t         op;
        logic [7:0]  owner;
        logic [31:0] size;
        logic [5:0]  idx;
        roll = $urandom_range(0, 99);
        case (mode)
            MODE_FILL:  op = (roll < 85) ? OP_ALLOC : op_t'(2'(roll));
            MODE_DRAIN: op = (roll < 45) ? OP_FREE :
                             (roll < 65) ? OP_FREE_OWNER :
                             (roll < 90) ? OP_QUERY : OP_ALLOC;
            default:    op = op_t'(2'(roll));
        endcase
        // small owner pool so free-by-owner finds matches
        owner = ($urandom_range(0, 4) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 3));
        case ($urandom_range(0, 9))
            0:       size = '0;
            1:       size = '1;
            2, 3:    size = 32'($urandom_range(1, 4096));
            default: size = $urandom();
        endcase
        idx = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(SLOT_COUNT, 63))
                                          : 6'($urandom_range(0, SLOT_COUNT - 1));
        return pack_req(op, owner, 3'($urandom()), size, idx);
    endfunction

    // Offer one beat, wait for it to be taken, then keep the burst going or pause
    task automatic send_req(input logic [55:0] beat);
        s_tdata  <= beat;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_tvalid <= 1'b0;
            repeat (($urandom_range(0, 3) == 0) ? $urandom_range(20, 90)
                                                : $urandom_range(1, 4))
                @(posedge aclk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(0, 6);
        end
    endtask

    // Result side: random short stalls while rx_phase[9] is low,
    // plus one long hold-off so the block backs up into its input
    always @(posedge aclk) begin
        rx_phase <= rx_phase + 1'b1;
        if (s_tvalid && s_tready) rx_accepts <= rx_accepts + 1;
        if (!held && rx_accepts >= HOLD_AFTER) begin
            held       <= 1'b1;
            stall_left <= HOLD_CYCLES;
            m_tready   <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (!rx_phase[9] && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 24);
            m_tready   <= 1'b0;
        end else begin
            m_tready   <= 1'b1;
        end
    end

    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("timeout after %0d cycles, %0d results outstanding", CYCLE_LIMIT, pending);
        $display("[slot_allocation_table] ERROR");
        $finish;
    end

    initial begin : stimulus
        traffic_t mode;
        mode = MODE_FILL;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: reserved slots, bad indexes, size extremes, holes, owner sweeps
        send_req(pack_req(OP_QUERY, 8'h00, 3'd0, 32'h0, 6'd0));         // reserved, size 0
        send_req(pack_req(OP_QUERY, 8'h00, 3'd0, 32'h0, 6'd59));        // unused slot
        send_req(pack_req(OP_QUERY, 8'h00, 3'd0, 32'h0, 6'd63));        // out of range
        send_req(pack_req(OP_FREE, 8'h00, 3'd0, 32'h0, 6'd60));         // out of range
        send_req(pack_req(OP_FREE, 8'h00, 3'd0, 32'h0, 6'd30));         // unused slot
        send_req(pack_req(OP_ALLOC, 8'hFF, 3'd7, 32'hFFFF_FFFF, 6'd0)); // first free
        send_req(pack_req(OP_ALLOC, 8'h00, 3'd0, 32'h0, 6'd0));         // zero size kept
        send_req(pack_req(OP_ALLOC, 8'h5A, 3'd2, 32'h8000_0001, 6'd0)); // total wraps
        send_req(pack_req(OP_QUERY, 8'h00, 3'd0, 32'h0, 6'd5));
        send_req(pack_req(OP_QUERY, 8'h00, 3'd0, 32'h0, 6'd7));
        send_req(pack_req(OP_FREE, 8'h00, 3'd0, 32'h0, 6'd2));          // reserved slot
        send_req(pack_req(OP_ALLOC, 8'h01, 3'd5, 32'h0000_1234, 6'd0)); // reuses the hole
        send_req(pack_req(OP_FREE, 8'h00, 3'd0, 32'h0, 6'd5));
        send_req(pack_req(OP_FREE, 8'h00, 3'd0, 32'h0, 6'd5));          // double free
        send_req(pack_req(OP_FREE_OWNER, 8'h77, 3'd0, 32'h0, 6'd0));    // no match
        send_req(pack_req(OP_FREE_OWNER, 8'h00, 3'd0, 32'h0, 6'd0));    // drops reserved
        send_req(pack_req(OP_QUERY, 8'h00, 3'd0, 32'h0, 6'd0));         // now unused
        send_req(pack_req(OP_FREE_OWNER, 8'hA5, 3'd0, 32'h0, 6'd0));
        send_req(pack_req(OP_FREE_OWNER, 8'h5A, 3'd0, 32'h0, 6'd0));
        send_req(pack_req(OP_ALLOC, 8'hA5, 3'd1, 32'hFFFF_FFFF, 6'd0));
        send_req(pack_req(OP_FREE, 8'h00, 3'd0, 32'h0, 6'd0));          // freed total wraps
        send_req(pack_req(OP_FREE, 8'h00, 3'd0, 32'h0, 6'd59));
        send_req(pack_req(OP_QUERY, 8'h00, 3'd0, 32'h0, 6'd62));

        // random: chunks of 100 beats, the first one filling the table
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k % 100 == 0 && k != 0) mode = traffic_t'($urandom_range(0, 2));
            send_req(random_req(mode));
        end
        s_tvalid <= 1'b0;

        // drain, then let the block settle
        do @(posedge aclk); while (pending != 0);
        repeat (2 * SLOT_COUNT) @(posedge aclk);

        $display("Sent %0d requests, checked %0d results, table peaked at %0d of %0d slots.",
                 rx_accepts, results_seen, peak_used, SLOT_COUNT);
        $display("Allocates refused on a full table: %0d, bad free/query: %0d, mismatches: %0d.",
                 full_seen, bad_seen, mismatches);
        if (mismatches == 0 && pending == 0) begin
            $display("[slot_allocation_table] OK");
        end else begin
            $display("[slot_allocation_table] ERROR");
        end
        $finish;
    end

endmodule

// ===== slot_allocation_table.f =====
rtl/sat_pkg.sv
rtl/sat_cell.sv
rtl/slot_allocation_table.sv
verif/sat_checker.sv
verif/tb_slot_allocation_table.sv
